### rtl/core/pcld_pkg.sv
// Shared types and codes for the page cache LRU tag directory.
// Used by pcld_entry_store, pcld_cmp_unit and page_cache_lru_directory_core.
`timescale 1ns / 1ps
`default_nettype none

package pcld_pkg;

  localparam int PAGE_W  = 16;
  localparam int ZOOM_W  = 32;
  localparam int STAMP_W = 32;

  localparam logic [1:0] MODE_LOOKUP  = 2'd0;
  localparam logic [1:0] MODE_INSTALL = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_MISS      = 3'd1,
    ST_BADPAGE   = 3'd2,
    ST_INSTALLED = 3'd3,
    ST_CLEARED   = 3'd4
  } status_e_t;

  typedef enum logic [2:0] {
    OP_LOOKUP,
    OP_INSTALL,
    OP_CLEAR,
    OP_BADPAGE,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [PAGE_W-1:0]  page;
    logic [ZOOM_W-1:0]  zoom;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic key_match;  // valid entry with the same page and zoom
    logic empty;      // entry not valid
    logic older;      // stamp below the current best
  } cmp_flags_t;

endpackage

`default_nettype wire

### rtl/core/pcld_entry_store.sv
// Directory entries: valid bits (cleared on reset) and key/stamp registers.
// One read port at the scan address, one write port. Depends on pcld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcld_entry_store
  import pcld_pkg::*;
#(
  parameter int ENTRIES = 8,
  parameter int IDX_W   = $clog2(ENTRIES)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               clear_all,
  input  wire logic               wr_key,
  input  wire logic               wr_stamp,
  input  wire logic [IDX_W-1:0]   wr_addr,
  input  wire logic [PAGE_W-1:0]  wr_page,
  input  wire logic [ZOOM_W-1:0]  wr_zoom,
  input  wire logic [STAMP_W-1:0] wr_stamp_val,
  input  wire logic [IDX_W-1:0]   rd_addr,
  output entry_t                  rd_entry
);

  logic [ENTRIES-1:0] valid;
  logic [PAGE_W-1:0]  page  [ENTRIES];
  logic [ZOOM_W-1:0]  zoom  [ENTRIES];
  logic [STAMP_W-1:0] stamp [ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (clear_all) begin
      valid <= '0;
    end else if (wr_key) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_key) begin
      page[wr_addr] <= wr_page;
      zoom[wr_addr] <= wr_zoom;
    end
    if (wr_key || wr_stamp) begin
      stamp[wr_addr] <= wr_stamp_val;
    end
  end

  always_comb begin
    rd_entry.valid = valid[rd_addr];
    rd_entry.page  = page[rd_addr];
    rd_entry.zoom  = zoom[rd_addr];
    rd_entry.stamp = stamp[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/core/pcld_cmp_unit.sv
// Shared compare unit: key match and stamp order for the entry under scan.
// Depends on pcld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcld_cmp_unit
  import pcld_pkg::*;
(
  input  wire entry_t             entry,
  input  wire logic [PAGE_W-1:0]  key_page,
  input  wire logic [ZOOM_W-1:0]  key_zoom,
  input  wire logic [STAMP_W-1:0] best_stamp,
  output cmp_flags_t              flags
);

  always_comb begin
    flags.key_match = entry.valid && (entry.page == key_page) && (entry.zoom == key_zoom);
    flags.empty     = !entry.valid;
    // strict less keeps the lowest index on ties
    flags.older     = entry.stamp < best_stamp;
  end

endmodule

`default_nettype wire

### rtl/core/page_cache_lru_directory_core.sv
// Page cache LRU tag directory: one entry is examined per cycle.
// Lookup/install scan entries in S_SCAN (at most ENTRIES; a lookup stops on a match,
// an install on an empty slot), then S_COMMIT; done is high in the cycle after commit.
// Clear, bad page and unused mode go straight to S_COMMIT, with done in the cycle after.
// One word at a time: start is taken only in S_IDLE; one compare unit serves the scan.
// Reset (rst, synchronous): all entries invalid, use clock and page limit zero.
// Results are not back-pressured; done is a one-cycle strobe.
`timescale 1ns / 1ps
`default_nettype none

module page_cache_lru_directory_core
  import pcld_pkg::*;
#(
  parameter int ENTRIES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  mode,
  input  wire logic [15:0] page_index,
  input  wire logic [31:0] zoom_key,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  output logic             done,
  output logic [2:0]       status,
  output logic [2:0]       slot,
  output logic             evicted,
  output logic [15:0]      evicted_page
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int EXT_W = (IDX_W < 3) ? 3 : IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t             state, state_next;
  op_t                op, op_next;
  logic [PAGE_W-1:0]  doc_pages;
  logic [PAGE_W-1:0]  req_page, req_page_next;
  logic [ZOOM_W-1:0]  req_zoom, req_zoom_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic               found, found_next;
  logic [IDX_W-1:0]   sel_idx, sel_idx_next;
  logic               vic_valid, vic_valid_next;
  logic [PAGE_W-1:0]  vic_page, vic_page_next;
  logic [STAMP_W-1:0] vic_stamp, vic_stamp_next;
  logic [STAMP_W-1:0] use_clock, use_clock_next;
  logic               done_next;
  logic [2:0]         status_next;
  logic [2:0]         slot_next;
  logic               evicted_next;
  logic [PAGE_W-1:0]  evicted_page_next;

  logic               clear_all, wr_key, wr_stamp;
  logic [STAMP_W-1:0] stamp_inc;
  logic [EXT_W-1:0]   sel_ext;
  entry_t             rd_entry;
  cmp_flags_t         flags;

  assign stamp_inc = use_clock + STAMP_W'(1);
  assign sel_ext   = EXT_W'(sel_idx);
  assign busy      = (state != S_IDLE);

  pcld_entry_store #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_store (
    .clk          (clk),
    .rst          (rst),
    .clear_all    (clear_all),
    .wr_key       (wr_key),
    .wr_stamp     (wr_stamp),
    .wr_addr      (sel_idx),
    .wr_page      (req_page),
    .wr_zoom      (req_zoom),
    .wr_stamp_val (stamp_inc),
    .rd_addr      (idx),
    .rd_entry     (rd_entry)
  );

  pcld_cmp_unit u_cmp (
    .entry      (rd_entry),
    .key_page   (req_page),
    .key_zoom   (req_zoom),
    .best_stamp (vic_stamp),
    .flags      (flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      doc_pages <= '0;
    end else if (cfg_we) begin
      doc_pages <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      use_clock <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      use_clock <= use_clock_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op           <= op_next;
    req_page     <= req_page_next;
    req_zoom     <= req_zoom_next;
    idx          <= idx_next;
    found        <= found_next;
    sel_idx      <= sel_idx_next;
    vic_valid    <= vic_valid_next;
    vic_page     <= vic_page_next;
    vic_stamp    <= vic_stamp_next;
    status       <= status_next;
    slot         <= slot_next;
    evicted      <= evicted_next;
    evicted_page <= evicted_page_next;
  end

  always_comb begin
    state_next        = state;
    op_next           = op;
    req_page_next     = req_page;
    req_zoom_next     = req_zoom;
    idx_next          = idx;
    found_next        = found;
    sel_idx_next      = sel_idx;
    vic_valid_next    = vic_valid;
    vic_page_next     = vic_page;
    vic_stamp_next    = vic_stamp;
    use_clock_next    = use_clock;
    done_next         = 1'b0;
    status_next       = status;
    slot_next         = slot;
    evicted_next      = evicted;
    evicted_page_next = evicted_page;
    clear_all         = 1'b0;
    wr_key            = 1'b0;
    wr_stamp          = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          req_page_next  = page_index;
          req_zoom_next  = zoom_key;
          idx_next       = '0;
          found_next     = 1'b0;
          sel_idx_next   = '0;
          vic_valid_next = 1'b0;
          if (mode == MODE_CLEAR) begin
            op_next = OP_CLEAR;
          end else if (mode != MODE_LOOKUP && mode != MODE_INSTALL) begin
            op_next = OP_NOP;
          end else if (page_index >= doc_pages) begin
            op_next = OP_BADPAGE;
          end else if (mode == MODE_LOOKUP) begin
            op_next = OP_LOOKUP;
          end else begin
            op_next = OP_INSTALL;
          end
          if ((mode == MODE_LOOKUP || mode == MODE_INSTALL) && page_index < doc_pages) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_COMMIT;
          end
        end
      end

      S_SCAN: begin
        idx_next = idx + IDX_W'(1);
        if (op == OP_LOOKUP) begin
          if (flags.key_match) begin
            found_next   = 1'b1;
            sel_idx_next = idx;
            state_next   = S_COMMIT;
          end else if (idx == LAST_IDX) begin
            state_next = S_COMMIT;
          end
        end else begin
          if (flags.empty) begin
            // first empty slot wins outright
            sel_idx_next   = idx;
            vic_valid_next = 1'b0;
            state_next     = S_COMMIT;
          end else begin
            if (idx == '0 || flags.older) begin
              sel_idx_next   = idx;
              vic_valid_next = 1'b1;
              vic_page_next  = rd_entry.page;
              vic_stamp_next = rd_entry.stamp;
            end
            if (idx == LAST_IDX) begin
              state_next = S_COMMIT;
            end
          end
        end
      end

      S_COMMIT: begin
        state_next        = S_IDLE;
        done_next         = 1'b1;
        slot_next         = 3'd0;
        evicted_next      = 1'b0;
        evicted_page_next = '0;
        unique case (op)
          OP_LOOKUP: begin
            if (found) begin
              wr_stamp       = 1'b1;
              use_clock_next = stamp_inc;
              status_next    = ST_HIT;
              slot_next      = sel_ext[2:0];
            end else begin
              status_next = ST_MISS;
            end
          end
          OP_INSTALL: begin
            wr_key            = 1'b1;
            use_clock_next    = stamp_inc;
            status_next       = ST_INSTALLED;
            slot_next         = sel_ext[2:0];
            evicted_next      = vic_valid;
            evicted_page_next = vic_valid ? vic_page : '0;
          end
          OP_CLEAR: begin
            clear_all   = 1'b1;
            status_next = ST_CLEARED;
          end
          OP_BADPAGE: begin
            status_next = ST_BADPAGE;
          end
          default: begin
            status_next = ST_MISS;
          end
        endcase
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // a result word follows every commit, never two in a row
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  a_done_on_release: assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("busy dropped without a result word");

  a_evict_install: assert property (@(posedge clk) disable iff (rst)
    (done && evicted) |-> (status == ST_INSTALLED))
    else $error("eviction reported outside an install");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (idx <= LAST_IDX))
    else $error("scan index beyond the last entry");

endmodule

`default_nettype wire

### tb/sv/page_cache_lru_directory_core_tb.sv
// Testbench for page_cache_lru_directory_core: directed and random lookup, install and
// clear words, checked against a shadow copy of the LRU tag directory kept in a class.
// Depends on pcld_pkg (mode codes, status enum) and the core RTL only.
`timescale 1ns / 1ps

module page_cache_lru_directory_core_tb
  import pcld_pkg::*;
();

  localparam int DIR_ENTRIES = 8;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    status_e_t   st;
    logic [2:0]  slot;
    logic        ev;
    logic [15:0] ev_page;
  } dir_answer_t;

  // Shadow directory: mirrors valid bits, keys, LRU stamps and the use clock.
  class page_dir_shadow;
    logic [15:0] doc_pages;
    bit          ent_valid [DIR_ENTRIES];
    logic [15:0] ent_page  [DIR_ENTRIES];
    logic [31:0] ent_zoom  [DIR_ENTRIES];
    logic [31:0] ent_stamp [DIR_ENTRIES];
    logic [31:0] use_clock;
    status_e_t   last_status;
    dir_answer_t answers_q[$];
    int unsigned errors;

    function new();
      doc_pages = '0;
      use_clock  = '0;
      errors     = 0;
      last_status = ST_MISS;
      for (int i = 0; i < DIR_ENTRIES; i++) begin
        ent_valid[i] = 1'b0;
        ent_page[i]  = '0;
        ent_zoom[i]  = '0;
        ent_stamp[i] = '0;
      end
    endfunction

    function int pending();
      return answers_q.size();
    endfunction

    function void note_word(logic [1:0] m, logic [15:0] p, logic [31:0] z);
      dir_answer_t a;
      int          victim;
      a.st = ST_MISS;
      a.slot = '0;
      a.ev = 1'b0;
      a.ev_page = '0;
      if (m == MODE_CLEAR) begin
        for (int i = 0; i < DIR_ENTRIES; i++) ent_valid[i] = 1'b0;
        a.st = ST_CLEARED;
      end else if (m == MODE_LOOKUP || m == MODE_INSTALL) begin
        if (p >= doc_pages) begin
          a.st = ST_BADPAGE;
        end else if (m == MODE_LOOKUP) begin
          // first matching entry wins, so duplicates resolve to the lower index
          for (int i = 0; i < DIR_ENTRIES; i++) begin
            if (ent_valid[i] && ent_page[i] == p && ent_zoom[i] == z) begin
              use_clock = use_clock + 1;
              ent_stamp[i] = use_clock;
              a.st = ST_HIT;
              a.slot = 3'(i);
              break;
            end
          end
        end else begin
          victim = 0;
          for (int i = 0; i < DIR_ENTRIES; i++) begin
            if (!ent_valid[i]) begin
              victim = i;
              break;
            end
            if (ent_stamp[i] < ent_stamp[victim]) victim = i;
          end
          if (ent_valid[victim]) begin
            a.ev = 1'b1;
            a.ev_page = ent_page[victim];
          end
          use_clock = use_clock + 1;
          ent_valid[victim] = 1'b1;
          ent_page[victim]  = p;
          ent_zoom[victim]  = z;
          ent_stamp[victim] = use_clock;
          a.st = ST_INSTALLED;
          a.slot = 3'(victim);
        end
      end
      last_status = a.st;
      answers_q.push_back(a);
    endfunction

    function void check_word(logic [2:0] s, logic [2:0] sl, logic e, logic [15:0] ep);
      dir_answer_t x;
      if (answers_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word status=%0d slot=%0d evicted=%0d evicted_page=%0d",
                 $time, s, sl, e, ep);
        return;
      end
      x = answers_q.pop_front();
      if (s !== x.st) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, x.st, s);
      end
      if (sl !== x.slot) begin
        errors++;
        $display("%0t: slot expected %0d actual %0d", $time, x.slot, sl);
      end
      if (e !== x.ev) begin
        errors++;
        $display("%0t: evicted expected %0d actual %0d", $time, x.ev, e);
      end
      if (ep !== x.ev_page) begin
        errors++;
        $display("%0t: evicted_page expected %0d actual %0d", $time, x.ev_page, ep);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  mode;
  logic [15:0] page_index;
  logic [31:0] zoom_key;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        done;
  logic [2:0]  status;
  logic [2:0]  slot;
  logic        evicted;
  logic [15:0] evicted_page;

  page_dir_shadow dir;
  bit             gaps_on;
  int unsigned    words_sent;

  logic [15:0] pool_page [12];
  logic [31:0] pool_zoom [12];

  page_cache_lru_directory_core #(.ENTRIES(DIR_ENTRIES)) DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .page_index   (page_index),
    .zoom_key     (zoom_key),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .status       (status),
    .slot         (slot),
    .evicted      (evicted),
    .evicted_page (evicted_page)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) dir.check_word(status, slot, evicted, evicted_page);
  end

  // Leaves start high on return so that words can be sent back to back.
  task automatic send_word(input logic [1:0] m, input logic [15:0] p, input logic [31:0] z);
    if (gaps_on && $urandom_range(99) < 18) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start      <= 1'b1;
    mode       <= m;
    page_index <= p;
    zoom_key   <= z;
    do @(posedge clk); while (busy);
    dir.note_word(m, p, z);
    words_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (dir.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_doc_pages(input logic [15:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    dir.doc_pages = v;
  endtask

  task automatic fill_key_pool(input logic [15:0] pc);
    for (int k = 0; k < 12; k++) begin
      if (k > 0 && k % 3 == 0) begin
        // same page, zoom off by one bit
        pool_page[k] = pool_page[k-1];
        pool_zoom[k] = pool_zoom[k-1] ^ (32'd1 << $urandom_range(31));
      end else begin
        pool_page[k] = (pc == 16'hFFFF) ? 16'($urandom) : 16'($urandom_range(0, pc));
        pool_zoom[k] = $urandom;
      end
    end
  endtask

  task automatic random_phase(input logic [15:0] pc, input int unsigned n_words);
    int unsigned stop_at;
    int          r;
    int          k;
    logic [15:0] kp;
    logic [31:0] kz;
    stop_at = words_sent + n_words;
    fill_key_pool(pc);
    while (words_sent < stop_at) begin
      k = $urandom_range(0, 11);
      kp = pool_page[k];
      kz = pool_zoom[k];
      if ($urandom_range(99) < 10) begin
        kp = 16'($urandom);
        kz = $urandom;
      end
      r = $urandom_range(99);
      if (r < 2) begin
        send_word(MODE_UNUSED, 16'($urandom), $urandom);
      end else if (r < 5) begin
        send_word(MODE_CLEAR, 16'($urandom), $urandom);
      end else if (r < 70) begin
        send_word(MODE_LOOKUP, kp, kz);
        if (dir.last_status == ST_MISS && $urandom_range(99) < 85)
          send_word(MODE_INSTALL, kp, kz);
      end else begin
        send_word(MODE_INSTALL, kp, kz);
      end
    end
  endtask

  initial begin
    logic [15:0] phase_pc [7];
    dir = new();
    gaps_on = 1'b0;
    words_sent = 0;
    rst        <= 1'b1;
    start      <= 1'b0;
    mode       <= MODE_LOOKUP;
    page_index <= '0;
    zoom_key   <= '0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // page count of zero: every page is out of range
    write_doc_pages(16'd0);
    send_word(MODE_LOOKUP, 16'd0, 32'd0);
    send_word(MODE_INSTALL, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(MODE_CLEAR, 16'd0, 32'd0);
    send_word(MODE_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);

    write_doc_pages(16'hFFFF);
    send_word(MODE_LOOKUP, 16'hFFFF, 32'd0);
    send_word(MODE_INSTALL, 16'hFFFE, 32'hFFFF_FFFF);
    send_word(MODE_INSTALL, 16'd0, 32'd0);
    send_word(MODE_LOOKUP, 16'hFFFE, 32'hFFFF_FFFF);
    send_word(MODE_LOOKUP, 16'd0, 32'd1);
    send_word(MODE_LOOKUP, 16'h5555, 32'hAAAA_AAAA);
    // duplicate key: lookup must land on the lower copy
    send_word(MODE_INSTALL, 16'd0, 32'd0);
    send_word(MODE_LOOKUP, 16'd0, 32'd0);
    for (int k = 0; k < 7; k++) send_word(MODE_INSTALL, 16'h1000 + 16'(k), 32'(k));
    send_word(MODE_LOOKUP, 16'd0, 32'd0);
    send_word(MODE_CLEAR, 16'd0, 32'd0);
    send_word(MODE_LOOKUP, 16'hFFFE, 32'hFFFF_FFFF);
    send_word(MODE_UNUSED, 16'd0, 32'd0);
    send_word(MODE_INSTALL, 16'h1234, 32'h3F80_0000);

    phase_pc = '{16'd12, 16'd1, 16'hFFFF, 16'd200, 16'd0, 16'd40, 16'd3};
    for (int ph = 0; ph < 7; ph++) begin
      write_doc_pages(phase_pc[ph]);
      gaps_on = (ph != 3);  // one long stretch at full rate
      random_phase(phase_pc[ph], (phase_pc[ph] == 16'd0) ? 50 : 300);
    end

    drain();
    repeat (20) @(posedge clk);
    if (dir.errors == 0 && dir.pending() == 0) begin
      $display("page_cache_lru_directory_core test passed");
    end else begin
      if (dir.pending() != 0)
        $display("%0t: %0d expected words never arrived", $time, dir.pending());
      $display("page_cache_lru_directory_core test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("page_cache_lru_directory_core test failed");
    $finish;
  end

endmodule

### page_cache_lru_directory_core.f
rtl/core/pcld_pkg.sv
rtl/core/pcld_entry_store.sv
rtl/core/pcld_cmp_unit.sv
rtl/core/page_cache_lru_directory_core.sv
tb/sv/page_cache_lru_directory_core_tb.sv
